// ===== rtl/nat_pkg.sv =====
// Shared constants, codes and types of the node address table.
package nat_pkg;

    // Table geometry
    localparam int NODES  = 64;
    localparam int IDX_W  = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int CNT_W  = $clog2(NODES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODES - 1);

    // Field widths
    localparam int OP_W     = 1;
    localparam int SHORT_W  = 16;
    localparam int EXT_W    = 64;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 6;
    localparam int COUNT_W  = 7;

    // Stream data widths, padded to whole bytes
    localparam int S_DATA_W = ((SHORT_W + EXT_W + 7) / 8) * 8;
    localparam int M_BITS   = STATUS_W + SLOT_W + COUNT_W + 1;
    localparam int M_DATA_W = ((M_BITS + 7) / 8) * 8;

    // Operation codes
    localparam logic [OP_W-1:0] OP_JOIN  = 1'b0;
    localparam logic [OP_W-1:0] OP_LEAVE = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

    // One stored table entry
    typedef struct packed {
        logic [SHORT_W-1:0] short_addr;
        logic [EXT_W-1:0]   ext_addr;
    } t_entry;

    // Access to the entry memory
    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        t_entry           wr_data;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
    } t_mem_req;

    // One result transaction
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot_index;
        logic [COUNT_W-1:0]  device_count;
        logic                list_changed;
    } t_result;

endpackage

// ===== rtl/node_address_table.sv =====
// Node address table: registered network nodes with join and leave by sequential scan.
// A transaction that matches slot k ends its scan there; a join of a new node, a full table
// or an unknown leave scans all NODES slots before its result shows.
// Throughput: one transaction at a time, set by the one-entry-per-cycle memory scan;
// the next is accepted the cycle after the result enters the output register.
// Reset (synchronous, active low) clears all valid marks and the count at once.
module node_address_table (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [nat_pkg::S_DATA_W-1:0]   i_s_tdata,  // short_addr[15:0], ext_addr[79:16]
    input  logic [nat_pkg::OP_W-1:0]       i_s_tuser,  // operation[0]
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [nat_pkg::M_DATA_W-1:0]   o_m_tdata   // status[2:0], slot_index[8:3],
                                                       // device_count[15:9], list_changed[16]
);

    logic              in_fire;
    logic              in_ready;
    nat_pkg::t_mem_req mem_req;
    nat_pkg::t_entry   rd_data;
    logic              res_valid;
    logic              res_take;
    nat_pkg::t_result  res;

    logic                         r_out_valid;
    logic [nat_pkg::M_DATA_W-1:0] r_out_data;
    logic [nat_pkg::M_DATA_W-1:0] n_out_data;

    assign in_fire    = i_s_tvalid && in_ready;
    assign o_s_tready = in_ready;

    nat_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_fire    (in_fire),
        .i_operation  (i_s_tuser),
        .i_short_addr (i_s_tdata[nat_pkg::SHORT_W-1:0]),
        .i_ext_addr   (i_s_tdata[nat_pkg::SHORT_W +: nat_pkg::EXT_W]),
        .o_in_ready   (in_ready),
        .o_mem_req    (mem_req),
        .i_rd_data    (rd_data),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .i_res_take   (res_take)
    );

    nat_mem u_mem (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    // Take a result when the output register is empty or draining
    assign res_take = res_valid && (!r_out_valid || i_m_tready);

    // Pack the result, lowest field first
    always_comb begin
        n_out_data = '0;
        n_out_data[nat_pkg::M_BITS-1:0] =
            {res.list_changed, res.device_count, res.slot_index, res.status};
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

// ===== rtl/nat_mem.sv =====
// Entry memory: short and extended address per slot, one write and one registered read port.
module nat_mem (
    input  logic               i_clk,
    input  nat_pkg::t_mem_req  i_req,
    output nat_pkg::t_entry    o_rd_data
);

    nat_pkg::t_entry mem [nat_pkg::NODES];
    nat_pkg::t_entry r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/nat_ctrl.sv =====
// Scan sequencer: valid bits, device count and the join / leave decision.
module nat_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_fire,
    input  logic [nat_pkg::OP_W-1:0]     i_operation,
    input  logic [nat_pkg::SHORT_W-1:0]  i_short_addr,
    input  logic [nat_pkg::EXT_W-1:0]    i_ext_addr,
    output logic                         o_in_ready,
    output nat_pkg::t_mem_req            o_mem_req,
    input  nat_pkg::t_entry              i_rd_data,
    output logic                         o_res_valid,
    output nat_pkg::t_result             o_res,
    input  logic                         i_res_take
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    localparam int IDX_W = nat_pkg::IDX_W;
    localparam int CNT_W = nat_pkg::CNT_W;

    function automatic logic [nat_pkg::SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
        logic [nat_pkg::SLOT_W+IDX_W-1:0] w;
        w = {{nat_pkg::SLOT_W{1'b0}}, idx};
        return w[nat_pkg::SLOT_W-1:0];
    endfunction

    function automatic logic [nat_pkg::COUNT_W-1:0] to_count(input logic [CNT_W-1:0] c);
        logic [nat_pkg::COUNT_W+CNT_W-1:0] w;
        w = {{nat_pkg::COUNT_W{1'b0}}, c};
        return w[nat_pkg::COUNT_W-1:0];
    endfunction

    logic [1:0]                   r_state, n_state;
    logic [nat_pkg::OP_W-1:0]     r_op;
    logic [nat_pkg::SHORT_W-1:0]  r_sa;
    logic [nat_pkg::EXT_W-1:0]    r_ea;
    logic [IDX_W-1:0]             r_rd_idx, n_rd_idx;
    logic                         r_issue, n_issue;
    logic                         r_chk_vld, n_chk_vld;
    logic [IDX_W-1:0]             r_chk_idx, n_chk_idx;
    logic                         r_free_found, n_free_found;
    logic [IDX_W-1:0]             r_free_idx, n_free_idx;
    logic [nat_pkg::NODES-1:0]    r_valid, n_valid;
    logic [CNT_W-1:0]             r_count, n_count;
    nat_pkg::t_result             r_res, n_res;

    logic             chk_v;
    logic             hit;
    logic             last_chk;
    logic             finish;
    logic             free_here;
    logic             free_any;
    logic [IDX_W-1:0] free_idx;

    // Evaluate the entry whose read data has just returned
    always_comb begin
        chk_v     = r_valid[r_chk_idx];
        hit       = r_chk_vld && chk_v &&
                    ((r_op == nat_pkg::OP_JOIN) ? (i_rd_data.ext_addr == r_ea)
                                                : (i_rd_data.short_addr == r_sa));
        last_chk  = r_chk_vld && (r_chk_idx == nat_pkg::LAST_IDX);
        finish    = (r_state == S_SCAN) && (hit || last_chk);
        free_here = r_chk_vld && !chk_v;
        free_any  = r_free_found || free_here;
        free_idx  = r_free_found ? r_free_idx : r_chk_idx;
    end

    // Next state, memory access and decision
    always_comb begin
        n_state      = r_state;
        n_rd_idx     = r_rd_idx;
        n_issue      = r_issue;
        n_chk_vld    = 1'b0;
        n_chk_idx    = r_chk_idx;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_valid      = r_valid;
        n_count      = r_count;
        n_res        = r_res;

        o_mem_req.wr_en   = 1'b0;
        o_mem_req.wr_addr = r_chk_idx;
        o_mem_req.wr_data = '{short_addr: r_sa, ext_addr: r_ea};
        o_mem_req.rd_en   = 1'b0;
        o_mem_req.rd_addr = r_rd_idx;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_fire) begin
                    n_state      = S_SCAN;
                    n_rd_idx     = '0;
                    n_issue      = 1'b1;
                    n_free_found = 1'b0;
                end
            end
            S_SCAN: begin
                // Issue one read a cycle
                if (r_issue) begin
                    o_mem_req.rd_en = 1'b1;
                    n_chk_vld       = 1'b1;
                    n_chk_idx       = r_rd_idx;
                    if (r_rd_idx == nat_pkg::LAST_IDX) begin
                        n_issue = 1'b0;
                    end else begin
                        n_rd_idx = r_rd_idx + IDX_W'(1);
                    end
                end
                // Remember the lowest free slot
                if (free_here && !r_free_found) begin
                    n_free_found = 1'b1;
                    n_free_idx   = r_chk_idx;
                end
                // Decide and write back
                if (finish) begin
                    n_state   = S_DONE;
                    n_chk_vld = 1'b0;
                    n_issue   = 1'b0;
                    if (hit && (r_op == nat_pkg::OP_JOIN)) begin
                        o_mem_req.wr_en = 1'b1;
                        n_res = '{status: nat_pkg::ST_UPDATED, slot_index: to_slot(r_chk_idx),
                                  device_count: to_count(r_count), list_changed: 1'b0};
                    end else if (hit) begin
                        n_valid[r_chk_idx] = 1'b0;
                        if (r_count != '0) begin
                            n_count = r_count - CNT_W'(1);
                        end
                        n_res = '{status: nat_pkg::ST_REMOVED, slot_index: to_slot(r_chk_idx),
                                  device_count: to_count(n_count), list_changed: 1'b1};
                    end else if ((r_op == nat_pkg::OP_JOIN) && free_any) begin
                        o_mem_req.wr_en   = 1'b1;
                        o_mem_req.wr_addr = free_idx;
                        n_valid[free_idx] = 1'b1;
                        n_count           = r_count + CNT_W'(1);
                        n_res = '{status: nat_pkg::ST_INSERTED, slot_index: to_slot(free_idx),
                                  device_count: to_count(n_count), list_changed: 1'b1};
                    end else if (r_op == nat_pkg::OP_JOIN) begin
                        n_res = '{status: nat_pkg::ST_FULL, slot_index: '0,
                                  device_count: to_count(r_count), list_changed: 1'b1};
                    end else begin
                        n_res = '{status: nat_pkg::ST_NOTFOUND, slot_index: '0,
                                  device_count: to_count(r_count), list_changed: 1'b0};
                    end
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_issue      <= 1'b0;
            r_chk_vld    <= 1'b0;
            r_free_found <= 1'b0;
            r_valid      <= '0;
            r_count      <= '0;
        end else begin
            r_state      <= n_state;
            r_issue      <= n_issue;
            r_chk_vld    <= n_chk_vld;
            r_free_found <= n_free_found;
            r_valid      <= n_valid;
            r_count      <= n_count;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_fire && (r_state == S_IDLE)) begin
            r_op <= i_operation;
            r_sa <= i_short_addr;
            r_ea <= i_ext_addr;
        end
        r_rd_idx   <= n_rd_idx;
        r_chk_idx  <= n_chk_idx;
        r_free_idx <= n_free_idx;
        r_res      <= n_res;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

`ifndef SYNTHESIS
    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_count))
        else $error("device count differs from number of valid slots");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= nat_pkg::NODES)
        else $error("device count above table size");

    a_write_only_on_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_req.wr_en |-> finish)
        else $error("entry write outside a scan decision");

    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_fire && o_in_ready) |=> (r_state == S_SCAN))
        else $error("accepted transaction did not start a scan");
`endif

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench of the node address table: join and leave stream with result check.
`timescale 1ns / 100ps

module testbench;

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 4;
    localparam int STALL_LIMIT  = 2000;   // cycles without any transaction
    localparam int TAIL_CYCLES  = 80;     // past the longest scan, which covers all NODES slots
    localparam int QUIET_TAIL   = 60;     // last requests are sent without idling
    localparam int RAND_BLOCKS  = 6;
    localparam int BLOCK_LEN    = 125;
    localparam int EXT_POOL_N   = 48;
    localparam int SHORT_POOL_N = 32;

    // One join or leave request as it waits for the driver
    typedef struct {
        logic [nat_pkg::OP_W-1:0]    op;
        logic [nat_pkg::SHORT_W-1:0] sa;
        logic [nat_pkg::EXT_W-1:0]   ea;
        bit                          drain_first;  // hold off until every result is back
        bit                          calm;         // no idling while this one is in flight
    } t_node_req;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_s_tvalid = 1'b0;
    logic                           o_s_tready;
    logic [nat_pkg::S_DATA_W-1:0]   i_s_tdata = '0;
    logic [nat_pkg::OP_W-1:0]       i_s_tuser = '0;
    logic                           o_m_tvalid;
    logic                           i_m_tready = 1'b0;
    logic [nat_pkg::M_DATA_W-1:0]   o_m_tdata;

    t_node_req         req_q[$];
    nat_pkg::t_result  result_q[$];

    // Own copy of the table
    bit                          tbl_valid [nat_pkg::NODES];
    logic [nat_pkg::SHORT_W-1:0] tbl_short [nat_pkg::NODES];
    logic [nat_pkg::EXT_W-1:0]   tbl_ext   [nat_pkg::NODES];
    int                          tbl_count;

    int         errors = 0;
    int         sent_cnt = 0;
    int         got_cnt = 0;
    int         idle_left = 0;
    int         stall_left = 0;
    int         quiet_cycles = 0;
    bit         idle_off = 1'b0;

    logic [nat_pkg::EXT_W-1:0]   ext_pool   [EXT_POOL_N];
    logic [nat_pkg::SHORT_W-1:0] short_pool [SHORT_POOL_N];

    node_address_table dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),   // short_addr[15:0], ext_addr[79:16]
        .i_s_tuser  (i_s_tuser),   // operation[0]
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)    // status[2:0], slot_index[8:3], device_count[15:9],
                                   // list_changed[16]
    );

    // Free-running clock
    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Apply one request to the table copy and give the result it must produce
    function automatic nat_pkg::t_result table_update(input t_node_req req);
        nat_pkg::t_result r;
        int               hit;
        r   = '0;
        hit = -1;
        if (req.op == nat_pkg::OP_JOIN) begin
            for (int i = 0; i < nat_pkg::NODES; i++)
                if (hit < 0 && tbl_valid[i] && tbl_ext[i] == req.ea) hit = i;
            if (hit >= 0) begin
                tbl_short[hit] = req.sa;
                r.status       = nat_pkg::ST_UPDATED;
                r.slot_index   = nat_pkg::SLOT_W'(hit);
                r.list_changed = 1'b0;
            end else begin
                for (int i = 0; i < nat_pkg::NODES; i++)
                    if (hit < 0 && !tbl_valid[i]) hit = i;
                r.list_changed = 1'b1;
                if (hit >= 0) begin
                    tbl_valid[hit] = 1'b1;
                    tbl_short[hit] = req.sa;
                    tbl_ext[hit]   = req.ea;
                    tbl_count++;
                    r.status       = nat_pkg::ST_INSERTED;
                    r.slot_index   = nat_pkg::SLOT_W'(hit);
                end else begin
                    r.status       = nat_pkg::ST_FULL;
                    r.slot_index   = '0;
                end
            end
        end else begin
            for (int i = 0; i < nat_pkg::NODES; i++)
                if (hit < 0 && tbl_valid[i] && tbl_short[i] == req.sa) hit = i;
            if (hit >= 0) begin
                tbl_valid[hit] = 1'b0;
                if (tbl_count > 0) tbl_count--;
                r.status       = nat_pkg::ST_REMOVED;
                r.slot_index   = nat_pkg::SLOT_W'(hit);
                r.list_changed = 1'b1;
            end else begin
                r.status       = nat_pkg::ST_NOTFOUND;
                r.slot_index   = '0;
                r.list_changed = 1'b0;
            end
        end
        r.device_count = nat_pkg::COUNT_W'(tbl_count);
        return r;
    endfunction

    task automatic add_req(input logic [nat_pkg::OP_W-1:0] op,
                           input logic [nat_pkg::SHORT_W-1:0] sa,
                           input logic [nat_pkg::EXT_W-1:0] ea,
                           input bit drain_first, input bit calm);
        t_node_req req;
        req.op          = op;
        req.sa          = sa;
        req.ea          = ea;
        req.drain_first = drain_first;
        req.calm        = calm;
        req_q.push_back(req);
    endtask

    function automatic logic [nat_pkg::EXT_W-1:0] rand_ext();
        return {$urandom, $urandom};
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Driver: present requests, predict each one as it is accepted
    always @(posedge i_clk) begin : req_driver
        bit accepted;
        bit quiet;
        accepted = i_s_tvalid && o_s_tready;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (accepted) begin
                result_q.push_back(table_update(req_q[0]));
                void'(req_q.pop_front());
                sent_cnt <= sent_cnt + 1;
            end
            quiet = (req_q.size() < QUIET_TAIL);
            if (accepted && !quiet && !idle_off && $urandom_range(0, 7) == 0)
                idle_left = $urandom_range(1, 10);
            if (accepted || !i_s_tvalid) begin
                if (idle_left > 0) begin
                    idle_left--;
                    i_s_tvalid <= 1'b0;
                end else if (req_q.size() > 0 &&
                             (!req_q[0].drain_first ||
                              sent_cnt + int'(accepted) == got_cnt)) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= {req_q[0].ea, req_q[0].sa};
                    i_s_tuser  <= req_q[0].op;
                    idle_off   <= req_q[0].calm || quiet;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result transaction, stall the output side at random
    always @(posedge i_clk) begin : result_monitor
        nat_pkg::t_result want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got_cnt <= got_cnt + 1;
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, o_m_tdata);
                    errors++;
                end else begin
                    want = result_q.pop_front();
                    check_field("status", want.status, o_m_tdata[2:0]);
                    check_field("slot_index", want.slot_index, o_m_tdata[8:3]);
                    check_field("device_count", want.device_count, o_m_tdata[15:9]);
                    check_field("list_changed", want.list_changed, o_m_tdata[16]);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else if (!idle_off && $urandom_range(0, 15) == 0) begin
                stall_left = $urandom_range(1, 10) - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin : watchdog
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Build the request list, release reset, wait for the table to settle
    initial begin : stimulus
        bit calm;
        bit join_heavy;
        bit drain_first;
        logic [nat_pkg::SHORT_W-1:0] sa;
        logic [nat_pkg::EXT_W-1:0]   ea;

        for (int i = 0; i < nat_pkg::NODES; i++) tbl_valid[i] = 1'b0;
        tbl_count = 0;

        // Directed: empty table, extremes, updates, duplicate short addresses, slot reuse
        add_req(nat_pkg::OP_LEAVE, 16'h0000, '0, 0, 0);
        add_req(nat_pkg::OP_LEAVE, 16'hFFFF, '1, 0, 0);
        add_req(nat_pkg::OP_JOIN,  16'h0000, 64'h0, 0, 0);
        add_req(nat_pkg::OP_JOIN,  16'hFFFF, '1, 0, 0);
        add_req(nat_pkg::OP_JOIN,  16'h1234, 64'h0, 0, 0);
        add_req(nat_pkg::OP_JOIN,  16'h1234, 64'h0123_4567_89AB_CDEF, 0, 0);
        add_req(nat_pkg::OP_JOIN,  16'h8000, 64'h8000_0000_0000_0000, 0, 0);
        add_req(nat_pkg::OP_JOIN,  16'h0001, 64'h0000_0000_0000_0001, 0, 0);
        add_req(nat_pkg::OP_LEAVE, 16'h1234, rand_ext(), 0, 0);
        add_req(nat_pkg::OP_LEAVE, 16'h1234, rand_ext(), 0, 0);
        add_req(nat_pkg::OP_LEAVE, 16'h1234, '0, 0, 0);
        add_req(nat_pkg::OP_JOIN,  16'hAAAA, 64'h0, 0, 0);
        add_req(nat_pkg::OP_JOIN,  16'h5555, '1, 0, 0);
        add_req(nat_pkg::OP_LEAVE, 16'hFFFF, '0, 0, 0);
        add_req(nat_pkg::OP_LEAVE, 16'h5555, '1, 0, 0);
        add_req(nat_pkg::OP_JOIN,  16'h5555, 64'h0123_4567_89AB_CDEF, 0, 0);
        add_req(nat_pkg::OP_LEAVE, 16'h8000, '0, 0, 0);
        add_req(nat_pkg::OP_LEAVE, 16'h0001, '0, 0, 0);
        add_req(nat_pkg::OP_LEAVE, 16'hAAAA, '0, 0, 0);
        add_req(nat_pkg::OP_LEAVE, 16'h5555, '0, 0, 0);
        add_req(nat_pkg::OP_LEAVE, 16'h0000, '0, 0, 0);

        // Address pools, so that updates, removals and duplicates recur
        ext_pool[0]   = '0;
        ext_pool[1]   = '1;
        for (int i = 2; i < EXT_POOL_N; i++) ext_pool[i] = rand_ext();
        short_pool[0] = 16'h0000;
        short_pool[1] = 16'hFFFF;
        for (int i = 2; i < SHORT_POOL_N; i++) short_pool[i] = 16'($urandom);

        // Random: join-heavy blocks fill the table past full, leave-heavy ones drain it
        for (int blk = 0; blk < RAND_BLOCKS; blk++) begin
            join_heavy = (blk % 2 == 0);
            calm       = (blk == 2);
            for (int n = 0; n < BLOCK_LEN; n++) begin
                drain_first = (n == 0 && (blk == 1 || blk == 3));
                sa = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                 : short_pool[$urandom_range(0, SHORT_POOL_N-1)];
                if ($urandom_range(0, 99) < (join_heavy ? 85 : 30)) begin
                    ea = ($urandom_range(0, 99) < 65) ? ext_pool[$urandom_range(0, EXT_POOL_N-1)]
                                                      : rand_ext();
                    add_req(nat_pkg::OP_JOIN, sa, ea, drain_first, calm);
                end else begin
                    add_req(nat_pkg::OP_LEAVE, sa, rand_ext(), drain_first, calm);
                end
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (req_q.size() > 0 || result_q.size() > 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
